// ===== rtl/core/hsv2rgb_pkg.sv =====
// Package for the HSV to RGB pixel converter.
// Holds the fixed-point constants, the sector codes and the beat structs
// passed between stages. No dependencies.
`default_nettype none

package hsv2rgb_pkg;

  // Hue is in degrees times 64.
  localparam int unsigned HUE_PERIOD = 360;
  localparam int unsigned HUE_SCALE  = 64;
  localparam int unsigned COLOR_MAX_DEFAULT = 255;

  localparam logic [15:0] HUE_WRAP   = 16'(HUE_PERIOD * HUE_SCALE);
  localparam logic [14:0] SECTOR_LEN = 15'(60 * HUE_SCALE);
  localparam logic [10:0] Q_ONE      = 11'd1024;

  // 1024 * 3840: the ramp term at full chroma
  localparam logic [21:0] W_FULL = 22'(1024 * 60 * HUE_SCALE);

  // floor(q/15) == (q * RECIP15) >> 16 for q < 3840
  localparam logic [12:0] RECIP15   = 13'd4370;
  localparam logic [11:0] DIV15_LIM = 12'd3840;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // Sector stage output: sector, distance to the ramp end, clamped s and v.
  typedef struct packed {
    sector_t     sector;
    logic [11:0] ramp_gap;
    logic [10:0] sat;
    logic [10:0] val;
  } sec_beat_t;

  // Product stage output, all already scaled by the color maximum.
  typedef struct packed {
    sector_t     sector;
    logic [47:0] p_mid;   // CM * v * w, over 2^28 * 15
    logic [36:0] p_lo;    // CM * v * (1024 - s), over 2^20
    logic [26:0] p_hi;    // CM * v, over 2^10
  } prod_beat_t;

endpackage

`default_nettype wire

// ===== rtl/core/hsv2rgb_sector.sv =====
// Hue wrap and sector split stage of the HSV to RGB converter.
// One register stage. Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_sector import hsv2rgb_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        up_valid,
  output      logic        up_ready,
  input  wire logic [15:0] hue,
  input  wire logic [10:0] saturation,
  input  wire logic [10:0] brightness,
  output      logic        dn_valid,
  input  wire logic        dn_ready,
  output      sec_beat_t   dn_beat
);

  logic        valid_r;
  sec_beat_t   beat_r;
  sec_beat_t   beat_nxt;
  logic [14:0] hw;
  logic [14:0] base;
  logic [11:0] f;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

  always_comb begin
    if (hue >= 16'(2 * HUE_WRAP)) begin
      hw = 15'(hue - 16'(2 * HUE_WRAP));
    end else if (hue >= HUE_WRAP) begin
      hw = 15'(hue - HUE_WRAP);
    end else begin
      hw = hue[14:0];
    end
  end

  always_comb begin
    beat_nxt = '0;
    if (hw < SECTOR_LEN) begin
      beat_nxt.sector = SEC_RED_YEL;
      base = 15'd0;
    end else if (hw < 15'(2 * SECTOR_LEN)) begin
      beat_nxt.sector = SEC_YEL_GRN;
      base = SECTOR_LEN;
    end else if (hw < 15'(3 * SECTOR_LEN)) begin
      beat_nxt.sector = SEC_GRN_CYN;
      base = 15'(2 * SECTOR_LEN);
    end else if (hw < 15'(4 * SECTOR_LEN)) begin
      beat_nxt.sector = SEC_CYN_BLU;
      base = 15'(3 * SECTOR_LEN);
    end else if (hw < 15'(5 * SECTOR_LEN)) begin
      beat_nxt.sector = SEC_BLU_MAG;
      base = 15'(4 * SECTOR_LEN);
    end else begin
      beat_nxt.sector = SEC_MAG_RED;
      base = 15'(5 * SECTOR_LEN);
    end
    f = 12'(hw - base);
    // ramp_gap = sector length minus the ramp position t
    if (beat_nxt.sector inside {SEC_YEL_GRN, SEC_CYN_BLU, SEC_MAG_RED}) begin
      beat_nxt.ramp_gap = f;
    end else begin
      beat_nxt.ramp_gap = 12'(SECTOR_LEN - 15'(f));
    end
    beat_nxt.sat = (saturation > Q_ONE) ? Q_ONE : saturation;
    beat_nxt.val = (brightness > Q_ONE) ? Q_ONE : brightness;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv2rgb_mult.sv =====
// Three-stage multiply pipeline of the HSV to RGB converter:
// ramp weight, products with v, then scaling by the color maximum.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_mult import hsv2rgb_pkg::*; #(
  parameter int unsigned COLOR_MAX = COLOR_MAX_DEFAULT
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output      logic       up_ready,
  input  wire sec_beat_t  up_beat,
  output      logic       dn_valid,
  input  wire logic       dn_ready,
  output      prod_beat_t dn_beat
);

  localparam logic [15:0] CM = 16'(COLOR_MAX);

  // stage A: w = 1024*3840 - s*gap, ns = 1024 - s
  logic        a_valid_r;
  sector_t     a_sector_r;
  logic [21:0] a_w_r;
  logic [10:0] a_ns_r;
  logic [10:0] a_v_r;
  logic [21:0] a_w_nxt;
  logic [22:0] s_gap;

  // stage B: v*w, v*ns
  logic        b_valid_r;
  sector_t     b_sector_r;
  logic [31:0] b_vw_r;
  logic [20:0] b_vn_r;
  logic [10:0] b_v_r;

  // stage C: times the color maximum
  logic        c_valid_r;
  prod_beat_t  c_beat_r;
  prod_beat_t  c_beat_nxt;

  logic a_ready;
  logic b_ready;
  logic c_ready;

  assign c_ready  = !c_valid_r || dn_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;
  assign dn_valid = c_valid_r;
  assign dn_beat  = c_beat_r;

  assign s_gap   = 23'(up_beat.sat) * 23'(up_beat.ramp_gap);
  assign a_w_nxt = 22'(23'(W_FULL) - s_gap);

  always_comb begin
    c_beat_nxt        = '0;
    c_beat_nxt.sector = b_sector_r;
    c_beat_nxt.p_mid  = 48'(b_vw_r) * 48'(CM);
    c_beat_nxt.p_lo   = 37'(b_vn_r) * 37'(CM);
    c_beat_nxt.p_hi   = 27'(b_v_r) * 27'(CM);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
      if (c_ready) begin
        c_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_sector_r <= up_beat.sector;
      a_w_r      <= a_w_nxt;
      a_ns_r     <= Q_ONE - up_beat.sat;
      a_v_r      <= up_beat.val;
    end
    if (b_ready && a_valid_r) begin
      b_sector_r <= a_sector_r;
      b_vw_r     <= 32'(a_v_r) * 32'(a_w_r);
      b_vn_r     <= 21'(a_v_r) * 21'(a_ns_r);
      b_v_r      <= a_v_r;
    end
    if (c_ready && b_valid_r) begin
      c_beat_r <= c_beat_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv2rgb_scale.sv =====
// Truncation, saturation and channel routing of the HSV to RGB converter.
// Two register stages; the second is the output register.
// Depends on hsv2rgb_pkg.
`default_nettype none

module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       up_valid,
  output      logic       up_ready,
  input  wire prod_beat_t up_beat,
  output      logic       dn_valid,
  input  wire logic       dn_ready,
  output      logic [7:0] red,
  output      logic [7:0] green,
  output      logic [7:0] blue
);

  // stage D: hi and lo done, mid reduced to the dividend for the divide by 15
  logic        d_valid_r;
  sector_t     d_sector_r;
  logic [7:0]  d_hi_r;
  logic [7:0]  d_lo_r;
  logic [11:0] d_q_r;
  logic        d_qsat_r;
  logic [16:0] hi_full;
  logic [16:0] lo_full;
  logic [19:0] q_full;

  // stage E: output register
  logic        e_valid_r;
  logic [7:0]  red_r;
  logic [7:0]  green_r;
  logic [7:0]  blue_r;
  logic [7:0]  red_nxt;
  logic [7:0]  green_nxt;
  logic [7:0]  blue_nxt;
  logic [24:0] q_prod;
  logic [7:0]  mid;

  logic d_ready;
  logic e_ready;

  assign e_ready  = !e_valid_r || dn_ready;
  assign d_ready  = !d_valid_r || e_ready;
  assign up_ready = d_ready;
  assign dn_valid = e_valid_r;
  assign red      = red_r;
  assign green    = green_r;
  assign blue     = blue_r;

  assign hi_full = up_beat.p_hi[26:10];
  assign lo_full = up_beat.p_lo[36:20];
  assign q_full  = up_beat.p_mid[47:28];

  // quotient by 15 via reciprocal; only valid below the saturation point
  assign q_prod = 25'(d_q_r) * 25'(RECIP15);
  assign mid    = d_qsat_r ? 8'hFF : q_prod[23:16];

  always_comb begin
    case (d_sector_r)
      SEC_RED_YEL: begin
        red_nxt = d_hi_r;  green_nxt = mid;    blue_nxt = d_lo_r;
      end
      SEC_YEL_GRN: begin
        red_nxt = mid;     green_nxt = d_hi_r; blue_nxt = d_lo_r;
      end
      SEC_GRN_CYN: begin
        red_nxt = d_lo_r;  green_nxt = d_hi_r; blue_nxt = mid;
      end
      SEC_CYN_BLU: begin
        red_nxt = d_lo_r;  green_nxt = mid;    blue_nxt = d_hi_r;
      end
      SEC_BLU_MAG: begin
        red_nxt = mid;     green_nxt = d_lo_r; blue_nxt = d_hi_r;
      end
      default: begin
        red_nxt = d_hi_r;  green_nxt = d_lo_r; blue_nxt = mid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      if (d_ready) begin
        d_valid_r <= up_valid;
      end
      if (e_ready) begin
        e_valid_r <= d_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && up_valid) begin
      d_sector_r <= up_beat.sector;
      d_hi_r     <= (hi_full > 17'd255) ? 8'hFF : hi_full[7:0];
      d_lo_r     <= (lo_full > 17'd255) ? 8'hFF : lo_full[7:0];
      d_qsat_r   <= q_full >= 20'(DIV15_LIM);
      d_q_r      <= q_full[11:0];
    end
    if (e_ready && d_valid_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsv_to_rgb_pixel_convert_unit.sv =====
// Top level of the HSV to RGB pixel converter: stream ports and the
// sector, multiply and scale stages. Depends on hsv2rgb_pkg,
// hsv2rgb_sector, hsv2rgb_mult and hsv2rgb_scale.
//
//   channel | direction | tdata fields (low bit first)
//   --------+-----------+---------------------------------------------
//   in_     | sink      | hue[15:0] saturation[26:16] brightness[37:27]
//   out_    | source    | red[7:0] green[15:8] blue[23:16]
//
// Six register stages; one pixel per cycle sustained while the output is not stalled.
// The depth is set by the multiply chain (s*gap, v*w, times COLOR_MAX)
// and the divide-by-15 reciprocal multiply ahead of the output register.
// Each stage has its own valid bit and advances when the next one is empty
// or moving, so bubbles close up while the output is stalled.
// Reset clears only the valid bits.
`default_nettype none

module hsv_to_rgb_pixel_convert_unit import hsv2rgb_pkg::*; #(
  parameter int unsigned COLOR_MAX = COLOR_MAX_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,   // hue[15:0], saturation[26:16], brightness[37:27]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic       sec_valid;
  logic       sec_ready;
  sec_beat_t  sec_beat;
  logic       prod_valid;
  logic       prod_ready;
  prod_beat_t prod_beat;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_tvalid),
    .up_ready   (in_tready),
    .hue        (in_tdata[15:0]),
    .saturation (in_tdata[26:16]),
    .brightness (in_tdata[37:27]),
    .dn_valid   (sec_valid),
    .dn_ready   (sec_ready),
    .dn_beat    (sec_beat)
  );

  hsv2rgb_mult #(
    .COLOR_MAX (COLOR_MAX)
  ) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (sec_valid),
    .up_ready (sec_ready),
    .up_beat  (sec_beat),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_beat  (prod_beat)
  );

  hsv2rgb_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_beat  (prod_beat),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  assign out_tdata = {blue, green, red};

endmodule

`default_nettype wire
